// ===== rtl/ssrds_pkg.sv =====
// Shared types, constants and digit helpers for the radio display scanner.
package ssrds_pkg;

	typedef logic [1:0] cfg_index_t;
	typedef logic [4:0] sym_t;
	typedef logic [3:0] digit_t;

	typedef struct packed {
		digit_t tens;
		digit_t ones;
	} tens_ones_t;

	typedef struct packed {
		digit_t hund;
		digit_t tens;
		digit_t ones;
	} digits3_t;

	localparam cfg_index_t CFG_IDLE_RELOAD = 2'd0;
	localparam cfg_index_t CFG_FREQ_LOW    = 2'd1;
	localparam cfg_index_t CFG_FREQ_HIGH   = 2'd2;

	localparam logic [15:0] IDLE_RELOAD_RST = 16'h1F40;
	localparam logic [13:0] FREQ_LOW_RST    = 14'd8700;
	localparam logic [13:0] FREQ_HIGH_RST   = 14'd10800;
	localparam logic [15:0] IDLE_COUNT_RST  = 16'h1F40;
	localparam logic [15:0] IDLE_EXPIRE_MAX = 16'd10;
	localparam logic [15:0] IDLE_PARKED     = 16'd5;

	localparam logic [7:0] MODE_CONNECT  = 8'd0;
	localparam logic [7:0] MODE_NO       = 8'd1;
	localparam logic [7:0] MODE_RSSI     = 8'd2;
	localparam logic [7:0] MODE_SLEEP    = 8'd3;
	localparam logic [7:0] MODE_VOLUME   = 8'd4;
	localparam logic [7:0] MODE_POLL     = 8'd5;
	localparam logic [7:0] MODE_DASHES   = 8'd6;
	localparam logic [7:0] MODE_FREQ     = 8'd10;
	localparam logic [7:0] MODE_AWAKE_MAX = 8'd100;
	localparam logic [7:0] MODE_SNR      = 8'd101;
	localparam logic [7:0] MODE_STANDBY  = 8'd102;
	localparam logic [7:0] MODE_RESET    = 8'd103;
	localparam logic [7:0] MODE_BAND     = 8'd104;

	localparam sym_t SYM_ONE        = 5'd1;
	localparam sym_t SYM_B          = 5'd12;
	localparam sym_t SYM_F          = 5'd16;
	localparam sym_t SYM_H          = 5'd21;
	localparam sym_t SYM_L          = 5'd22;
	localparam sym_t SYM_S          = 5'd23;
	localparam sym_t SYM_N          = 5'd24;
	localparam sym_t SYM_SMALL_N    = 5'd25;
	localparam sym_t SYM_UNDERSCORE = 5'd26;
	localparam sym_t SYM_DASH       = 5'd27;
	localparam sym_t SYM_ZERO       = 5'd0;
	localparam sym_t SYM_BLANK      = 5'd31;
	localparam sym_t SYM_COUNT      = 5'd28;

	localparam logic [7:0] SEG_DOT_MASK = 8'h7F;

	// Reciprocal constants for the digit helpers; each frequency digit is the
	// fractional part of v / 10^(k+1) scaled by ten.
	localparam logic [14:0] RECIP_10000 = 15'd26844;
	localparam logic [15:0] RECIP_1000  = 16'd33555;
	localparam logic [14:0] RECIP_100   = 15'd20972;
	localparam logic [7:0]  RECIP_10    = 8'd205;

	function automatic logic [7:0] seg_rom(input sym_t s);
		logic [7:0] r;
		case (s)
			5'd0:  r = 8'hC0;
			5'd1:  r = 8'hF9;
			5'd2:  r = 8'hA4;
			5'd3:  r = 8'hB0;
			5'd4:  r = 8'h99;
			5'd5:  r = 8'h92;
			5'd6:  r = 8'h82;
			5'd7:  r = 8'hF8;
			5'd8:  r = 8'h80;
			5'd9:  r = 8'h90;
			5'd10: r = 8'h7F;
			5'd11: r = 8'h88;
			5'd12: r = 8'h83;
			5'd13: r = 8'hC6;
			5'd14: r = 8'hA1;
			5'd15: r = 8'h86;
			5'd16: r = 8'h8E;
			5'd17: r = 8'h8C;
			5'd18: r = 8'hC1;
			5'd19: r = 8'hCE;
			5'd20: r = 8'h91;
			5'd21: r = 8'h89;
			5'd22: r = 8'hC7;
			5'd23: r = 8'h12;
			5'd24: r = 8'hC8;
			5'd25: r = 8'hAB;
			5'd26: r = 8'hF7;
			5'd27: r = 8'hBF;
			default: r = 8'hFF;
		endcase
		return r;
	endfunction

	// Tens and ones of a value below 128.
	function automatic tens_ones_t split_tens(input logic [6:0] v);
		logic [14:0] p;
		tens_ones_t  r;
		p = 15'(v) * 15'(RECIP_10);
		r.tens = p[14:11];
		r.ones = 4'(v - 7'(r.tens) * 7'd10);
		return r;
	endfunction

	function automatic digits3_t split_byte(input logic [7:0] v);
		logic [7:0] rem;
		tens_ones_t to;
		digits3_t   r;
		if (v >= 8'd200) begin
			r.hund = 4'd2;
			rem = v - 8'd200;
		end else if (v >= 8'd100) begin
			r.hund = 4'd1;
			rem = v - 8'd100;
		end else begin
			r.hund = 4'd0;
			rem = v;
		end
		to = split_tens(rem[6:0]);
		r.tens = to.tens;
		r.ones = to.ones;
		return r;
	endfunction

	function automatic digit_t freq_thousands(input logic [13:0] v);
		logic [28:0] p;
		logic [31:0] t;
		p = 29'(v) * 29'(RECIP_10000);
		t = ({4'b0, p[27:0]} << 3) + ({4'b0, p[27:0]} << 1);
		return t[31:28];
	endfunction

	function automatic digit_t freq_hundreds(input logic [13:0] v);
		logic [29:0] p;
		logic [28:0] t;
		p = 30'(v) * 30'(RECIP_1000);
		t = ({4'b0, p[24:0]} << 3) + ({4'b0, p[24:0]} << 1);
		return t[28:25];
	endfunction

	function automatic digit_t freq_tens(input logic [13:0] v);
		logic [28:0] p;
		logic [24:0] t;
		p = 29'(v) * 29'(RECIP_100);
		t = ({4'b0, p[20:0]} << 3) + ({4'b0, p[20:0]} << 1);
		return t[24:21];
	endfunction

endpackage

// ===== rtl/seven_segment_radio_display_scanner.sv =====
// Four-digit multiplexed seven-segment display scanner for a radio front panel.
//
// Each input item is one scan tick. It carries the display mode and the values
// to show; the block answers with one result item that drives the segment byte
// and the digit lines for the digit at the current scan position, or the idle
// blanking once the countdown has run out.
// Configuration writes set the idle reload value and the frequency wrap bounds;
// they are taken at any edge with cfg_write high and must only come while idle.
// A result item passes through one input register and one result register,
// with all work done between them. One item per cycle is sustained while the
// receiver does not stall; the frequency step and digit split are done
// combinationally between the two registers.
// When the receiver stalls, the result holds and one further item waits in the
// input register; in_stall rises only when both are full.
// Reset clears both valid flags, puts the scan at digit zero, the shown
// frequency at 87.00 MHz, the idle countdown at 8000 ticks and the registers
// at their defaults.
module seven_segment_radio_display_scanner (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  ssrds_pkg::cfg_index_t cfg_index,
	input  logic [15:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            display_mode,
	input  logic [13:0]           target_freq,
	input  logic                  seek_up,
	input  logic [6:0]            volume,
	input  logic [7:0]            rssi,
	input  logic [7:0]            snr,
	input  logic [6:0]            band,
	input  logic                  sleep_mode,
	input  logic                  poll_flag,
	input  logic [7:0]            standby_minutes,
	input  logic                  wake,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            seg_byte,
	output logic                  seg_write,
	output logic [3:0]            digit_enable_n,
	output logic                  digit_update,
	output logic                  display_off
);
	import ssrds_pkg::*;

	logic        s1_valid_q;
	logic        out_valid_q;
	logic [15:0] idle_reload_q;
	logic [13:0] freq_low_q;
	logic [13:0] freq_high_q;
	logic [1:0]  scan_q;
	logic [13:0] shown_q;
	logic [15:0] idle_q;

	logic [7:0]  mode_s1;
	logic [13:0] target_s1;
	logic        seek_up_s1;
	logic [6:0]  volume_s1;
	logic [7:0]  rssi_s1;
	logic [7:0]  snr_s1;
	logic [6:0]  band_s1;
	logic        sleep_s1;
	logic        poll_s1;
	logic [7:0]  standby_s1;
	logic        wake_s1;

	logic [7:0]  seg_byte_q;
	logic        seg_write_q;
	logic [3:0]  digit_enable_n_q;
	logic        digit_update_q;
	logic        display_off_q;

	logic        in_accept;
	logic        advance;

	logic [1:0]  scan_next;
	logic [13:0] shown_next;
	logic [15:0] idle_next;
	logic [7:0]  seg_byte_d;
	logic        seg_write_d;
	logic [3:0]  digit_enable_n_d;
	logic        digit_update_d;
	logic        display_off_d;

	assign advance   = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall  = s1_valid_q && !advance;
	assign in_accept = in_valid && !in_stall;

	always_comb begin
		logic [15:0] idle_eff;
		logic        show;
		logic        mode_ok;
		logic [13:0] stepped;
		sym_t        sym [4];
		sym_t        cur;
		logic        dot_here;
		logic        freq_dot;
		digits3_t    d3;
		tens_ones_t  d2;
		idle_eff = (wake_s1 && !sleep_s1) ? idle_reload_q : idle_q;
		stepped = shown_q;
		if (shown_q != target_s1) begin
			if (seek_up_s1) begin
				stepped = (shown_q >= freq_high_q) ? freq_low_q : shown_q + 14'd1;
			end else begin
				stepped = (shown_q <= freq_low_q) ? freq_high_q : shown_q - 14'd1;
			end
		end
		mode_ok = 1'b1;
		freq_dot = 1'b0;
		d3 = '0;
		d2 = '0;
		for (int i = 0; i < 4; i++) begin
			sym[i] = SYM_BLANK;
		end
		case (mode_s1)
			MODE_FREQ: begin
				if (stepped == 14'd0) begin
					for (int i = 0; i < 4; i++) begin
						sym[i] = SYM_F;
					end
				end else begin
					sym[0] = (stepped >= 14'd10000) ? SYM_ONE : SYM_BLANK;
					sym[1] = sym_t'(freq_thousands(stepped));
					sym[2] = sym_t'(freq_hundreds(stepped));
					sym[3] = sym_t'(freq_tens(stepped));
					freq_dot = 1'b1;
				end
			end
			MODE_CONNECT: begin
				sym[2] = SYM_UNDERSCORE;
				sym[3] = SYM_UNDERSCORE;
			end
			MODE_NO: begin
				sym[2] = SYM_N;
				sym[3] = SYM_ZERO;
			end
			MODE_RSSI: begin
				d3 = split_byte(rssi_s1);
				sym[1] = (d3.hund != 4'd0) ? sym_t'(d3.hund) : SYM_BLANK;
				sym[2] = sym_t'(d3.tens);
				sym[3] = sym_t'(d3.ones);
			end
			MODE_SLEEP: begin
				sym[0] = SYM_S;
				sym[3] = sleep_s1 ? SYM_H : SYM_L;
			end
			MODE_VOLUME: begin
				d2 = split_tens(volume_s1);
				sym[1] = sym_t'(d2.tens);
				sym[2] = sym_t'(d2.ones);
			end
			MODE_POLL: begin
				sym[0] = SYM_S;
				sym[3] = sym_t'(poll_s1);
			end
			MODE_DASHES: begin
				for (int i = 0; i < 4; i++) begin
					sym[i] = SYM_DASH;
				end
			end
			MODE_SNR: begin
				d3 = split_byte(snr_s1);
				sym[0] = SYM_S;
				sym[1] = SYM_SMALL_N;
				sym[2] = sym_t'(d3.tens);
				sym[3] = sym_t'(d3.ones);
			end
			MODE_STANDBY: begin
				d3 = split_byte(standby_s1);
				sym[0] = SYM_L;
				sym[1] = (d3.hund != 4'd0) ? sym_t'(d3.hund) : SYM_BLANK;
				sym[2] = sym_t'(d3.tens);
				sym[3] = sym_t'(d3.ones);
			end
			MODE_RESET: begin
				sym[0] = SYM_UNDERSCORE;
				sym[1] = SYM_UNDERSCORE;
				sym[2] = SYM_DASH;
				sym[3] = SYM_DASH;
			end
			MODE_BAND: begin
				d2 = split_tens(band_s1);
				sym[0] = SYM_B;
				sym[2] = sym_t'(d2.tens);
				sym[3] = sym_t'(d2.ones);
			end
			default: begin
				mode_ok = 1'b0;
			end
		endcase

		cur = sym[scan_q];
		dot_here = freq_dot && (scan_q == 2'd2) && (cur < 5'd10);

		scan_next = scan_q;
		shown_next = shown_q;
		idle_next = idle_eff;
		seg_byte_d = 8'h00;
		seg_write_d = 1'b0;
		digit_enable_n_d = 4'hF;
		digit_update_d = 1'b0;
		display_off_d = 1'b0;

		show = 1'b0;
		if (sleep_s1 || mode_s1 > MODE_AWAKE_MAX) begin
			show = 1'b1;
		end else if (idle_eff > IDLE_EXPIRE_MAX) begin
			show = 1'b1;
			idle_next = idle_eff - 16'd1;
		end else begin
			idle_next = IDLE_PARKED;
			digit_update_d = (idle_eff != IDLE_PARKED);
			display_off_d = 1'b1;
		end

		if (show && mode_ok) begin
			if (mode_s1 == MODE_FREQ) begin
				shown_next = stepped;
			end
			digit_update_d = 1'b1;
			scan_next = scan_q + 2'd1;
			if (cur < SYM_COUNT) begin
				seg_byte_d = dot_here ? (seg_rom(cur) & SEG_DOT_MASK) : seg_rom(cur);
				seg_write_d = 1'b1;
				digit_enable_n_d = ~(4'b0001 << scan_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			idle_reload_q <= IDLE_RELOAD_RST;
			freq_low_q    <= FREQ_LOW_RST;
			freq_high_q   <= FREQ_HIGH_RST;
			scan_q        <= 2'd0;
			shown_q       <= FREQ_LOW_RST;
			idle_q        <= IDLE_COUNT_RST;
		end else begin
			if (in_accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write) begin
				case (cfg_index)
					CFG_IDLE_RELOAD: idle_reload_q <= cfg_data;
					CFG_FREQ_LOW:    freq_low_q <= cfg_data[13:0];
					CFG_FREQ_HIGH:   freq_high_q <= cfg_data[13:0];
					default: ;
				endcase
			end
			if (advance) begin
				scan_q  <= scan_next;
				shown_q <= shown_next;
				idle_q  <= idle_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_s1    <= display_mode;
			target_s1  <= target_freq;
			seek_up_s1 <= seek_up;
			volume_s1  <= volume;
			rssi_s1    <= rssi;
			snr_s1     <= snr;
			band_s1    <= band;
			sleep_s1   <= sleep_mode;
			poll_s1    <= poll_flag;
			standby_s1 <= standby_minutes;
			wake_s1    <= wake;
		end
		if (advance) begin
			seg_byte_q       <= seg_byte_d;
			seg_write_q      <= seg_write_d;
			digit_enable_n_q <= digit_enable_n_d;
			digit_update_q   <= digit_update_d;
			display_off_q    <= display_off_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign seg_byte       = seg_byte_q;
	assign seg_write      = seg_write_q;
	assign digit_enable_n = digit_enable_n_q;
	assign digit_update   = digit_update_q;
	assign display_off    = display_off_q;

`ifndef ASSERT_OFF
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && out_valid_q && out_stall))
		else $error("input stalled while a register stage was free");

	a_one_digit_lit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && seg_write) |-> ($onehot(~digit_enable_n) && digit_update))
		else $error("segment write without exactly one digit selected");

	a_blank_no_segments: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && display_off) |-> (!seg_write && digit_enable_n == 4'hF))
		else $error("segments driven while the display is blanked");

	a_result_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !in_stall) |=> out_valid)
		else $error("queued item did not reach the result register");
`endif

endmodule
